// File: rtl/core/half_db_volume_scaler_unit_assert.svh
// Assertion macros for the volume scaler checker.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef HALF_DB_VOLUME_SCALER_UNIT_ASSERT_SVH
`define HALF_DB_VOLUME_SCALER_UNIT_ASSERT_SVH

// Clocked assertion with explicit clock and active-low reset
`define HDVS_ASSERT_CLK(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
		else $error("half_db_volume_scaler_unit: assertion failed");

// Same, on the block's own clk and arst_n
`define HDVS_ASSERT(lbl, prop) \
	`HDVS_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

// File: rtl/core/hdvs_pkg.sv
// Package for the half-dB volume scaler: register codes, gain table, types.
// No dependencies; used by every module of the block.
package hdvs_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned GAIN_W   = 22;
	localparam int unsigned VOL_W    = 8;
	localparam int unsigned IDX_W    = 2;

	// Register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_VOLUME = 2'd0;
	localparam logic [IDX_W-1:0] REG_MUTE   = 2'd1;

	localparam logic [63:0] UP_FACTOR   = 64'd69419;
	localparam logic [63:0] DOWN_FACTOR = 64'd61870;
	localparam logic [63:0] ROUND_HALF  = 64'd32768;
	localparam logic [63:0] UNITY_GAIN  = 64'd65536;
	localparam int          UNITY_VOL   = 60;
	localparam int          MAX_STEPS   = 60;
	localparam int          MIN_STEPS   = -89;

	localparam logic signed [VOL_W-1:0]    MUTE_VOLUME = -8'sd30;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX  = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN  = -16'sh8000;
	localparam logic [GAIN_W-1:0]          GAIN_RESET  = 22'd65536;

	typedef logic [(2**VOL_W)-1:0][GAIN_W-1:0] gain_tab_t;

	// Gain and zeroing control handed from the config block to the datapath
	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic              zero;
	} hdvs_gain_t;

	// Gain for every 8-bit volume code, built at elaboration by repeated
	// rounded multiplication per half-dB step.
	function automatic gain_tab_t build_gain_tab();
		gain_tab_t   tab;
		logic [63:0] g;
		int          vol;
		int          steps;
		for (int c = 0; c < 2**VOL_W; c++) begin
			vol = (c >= 2**(VOL_W-1)) ? c - 2**VOL_W : c;
			steps = vol - UNITY_VOL;
			if (steps > MAX_STEPS)
				steps = MAX_STEPS;
			if (steps < MIN_STEPS)
				steps = MIN_STEPS;
			g = UNITY_GAIN;
			for (int i = 0; i < steps; i++)
				g = (g * UP_FACTOR + ROUND_HALF) >> 16;
			for (int i = 0; i < -steps; i++)
				g = (g * DOWN_FACTOR + ROUND_HALF) >> 16;
			tab[c] = g[GAIN_W-1:0];
		end
		return tab;
	endfunction

	localparam gain_tab_t GAIN_TAB = build_gain_tab();

endpackage

// File: rtl/core/hdvs_gain_reg.sv
// Configuration registers of the volume scaler: volume and mute.
// Depends on hdvs_pkg; the gain is looked up in the package gain table.
module hdvs_gain_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hdvs_pkg::IDX_W-1:0] cfg_index,
	input  logic [hdvs_pkg::VOL_W-1:0] cfg_wdata,
	output hdvs_pkg::hdvs_gain_t       gain_ctl
);
	import hdvs_pkg::*;

	logic [GAIN_W-1:0] gain_q;
	logic              vol_zero_q;
	logic              mute_q;

	// Register writes; a volume write loads the gain for that code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= GAIN_RESET;
			vol_zero_q <= 1'b0;
			mute_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VOLUME: begin
					gain_q     <= GAIN_TAB[cfg_wdata];
					vol_zero_q <= ($signed(cfg_wdata) <= MUTE_VOLUME);
				end
				REG_MUTE: begin
					mute_q <= cfg_wdata[0];
				end
				default: begin
					// unused index: ignored
				end
			endcase
		end
	end

	assign gain_ctl.gain = gain_q;
	assign gain_ctl.zero = vol_zero_q | mute_q;

endmodule

// File: rtl/core/hdvs_scale.sv
// Sample datapath: gain multiply, floor by 2^16, saturate, zero forcing.
// Depends on hdvs_pkg.
module hdvs_scale (
	input  logic signed [hdvs_pkg::SAMPLE_W-1:0] sample_in,
	input  hdvs_pkg::hdvs_gain_t                 gain_ctl,
	output logic signed [hdvs_pkg::SAMPLE_W-1:0] sample_out
);
	import hdvs_pkg::*;

	localparam int unsigned PROD_W = SAMPLE_W + GAIN_W + 1;

	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-17:0]     floored;
	logic                          hi_ovf;
	logic                          lo_ovf;

	// Signed sample times unsigned gain; arithmetic shift floors
	assign prod    = PROD_W'(sample_in) * $signed({1'b0, gain_ctl.gain});
	assign floored = prod[PROD_W-1:16];

	// Out of range when the bits above the 16-bit result disagree
	assign hi_ovf = !floored[PROD_W-17] && (|floored[PROD_W-17:SAMPLE_W-1]);
	assign lo_ovf = floored[PROD_W-17] && !(&floored[PROD_W-17:SAMPLE_W-1]);

	always_comb begin
		if (gain_ctl.zero)
			sample_out = '0;
		else if (hi_ovf)
			sample_out = SAMPLE_MAX;
		else if (lo_ovf)
			sample_out = SAMPLE_MIN;
		else
			sample_out = floored[SAMPLE_W-1:0];
	end

endmodule

// File: rtl/core/half_db_volume_scaler_unit.sv
// Half-dB digital volume scaler, top level.
// Depends on hdvs_pkg, hdvs_gain_reg and hdvs_scale.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one signed 16-bit PCM sample
//   and its frame-end flag per transfer; output channel
//   (out_valid/out_ready) returns the scaled sample and last_out.
// - Config port: cfg_we with cfg_index 0 writes volume (signed, half-dB
//   steps, 60 is unity), index 1 writes mute. The gain for the new volume
//   is read from a constant table and is in use in the cycle after the write.
//   Write only while no sample is in flight.
// - Path: the input register loads at the input transfer; multiply and
//   saturate feed the result register, which drives out_valid and
//   scaled_sample.
// - Throughput: one sample per cycle while out_ready is high; the two registers have separate enables.
// - Stall: while out_ready is low the result holds; the input register
//   still takes one more sample, then in_ready drops.
// - Reset: both stages empty, volume 60 (unity gain), mute off.
module half_db_volume_scaler_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [hdvs_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [hdvs_pkg::SAMPLE_W-1:0] scaled_sample,
	output logic                                 last_out,
	input  logic                                 cfg_we,
	input  logic [hdvs_pkg::IDX_W-1:0]           cfg_index,
	input  logic [hdvs_pkg::VOL_W-1:0]           cfg_wdata
);
	import hdvs_pkg::*;

	hdvs_gain_t                 gain_ctl;
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       last_s1;
	logic                       valid_s2;
	logic signed [SAMPLE_W-1:0] sample_s2;
	logic                       last_s2;
	logic signed [SAMPLE_W-1:0] scaled;
	logic                       adv_s2;

	hdvs_gain_reg u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.gain_ctl  (gain_ctl)
	);

	hdvs_scale u_scale (
		.sample_in  (sample_s1),
		.gain_ctl   (gain_ctl),
		.sample_out (scaled)
	);

	// Stage 2 moves when empty or its result is taken
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= sample;
			last_s1   <= last;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			sample_s2 <= scaled;
			last_s2   <= last_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign scaled_sample = sample_s2;
	assign last_out      = last_s2;

endmodule

// File: rtl/core/hdvs_checker.sv
// Port-level checker for half_db_volume_scaler_unit, bound to the top level.
// Depends on hdvs_pkg and the assertion macros header.
`include "half_db_volume_scaler_unit_assert.svh"

module hdvs_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [hdvs_pkg::SAMPLE_W-1:0] scaled_sample,
	input logic                                 last_out
);
	import hdvs_pkg::*;

	// A stalled result holds
	`HDVS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(scaled_sample) && $stable(last_out))

	// A result appearing in an empty output stage came from an input transfer through the input register
	`HDVS_ASSERT(a_out_source, $rose(out_valid) |-> $past(in_valid && in_ready, 2))

	// With the output stage empty the block always takes input
	`HDVS_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)

endmodule

bind half_db_volume_scaler_unit hdvs_checker u_hdvs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.scaled_sample (scaled_sample),
	.last_out      (last_out)
);
